### rtl/modbus_rtu_response_parser_core_defines.svh
// ----------------------------------------------------------------------------
// Modbus RTU response parser: assertion macros
// Shared property shorthands for the checker of the parser core.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_RESPONSE_PARSER_CORE_DEFINES_SVH
`define MODBUS_RTU_RESPONSE_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MRP_ASSERT_IMP(label, ck, rn, pre, post) \
	label: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
		else $error("parser check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MRP_ASSERT_NXT(label, ck, rn, pre, post) \
	label: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
		else $error("parser check failed");

`endif

### rtl/mrp_pkg.sv
// ----------------------------------------------------------------------------
// Modbus RTU response parser package
// Types, constants and helper functions shared by the parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mrp_pkg;

	// Frame geometry.
	localparam int MAX_FRAME_BYTES = 256;
	localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);
	// Lengths derived from the byte count field reach 5 + 255.
	localparam int LEN_W           = 10;

	// CRC-16 as used on the serial line.
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Reported quantities saturate here.
	localparam logic [10:0] QTY_MAX = 11'd2040;

	// Function codes.
	localparam logic [7:0] FC_READ_COILS    = 8'd1;
	localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
	localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
	localparam logic [7:0] FC_READ_INPUT    = 8'd4;
	localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
	localparam logic [7:0] FC_WRITE_REG     = 8'd6;
	localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
	localparam logic [7:0] FC_WRITE_REGS    = 8'd16;

	// A single coil write with this high byte turns the coil on.
	localparam logic [7:0] COIL_ON = 8'hFF;

	// Summary status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_MALFORMED = 2'd1;
	localparam logic [1:0] ST_BAD_CRC   = 2'd2;

	// Result kinds.
	localparam logic KIND_VALUE   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Depth of the job queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} frame_t;

	typedef struct packed {
		logic        item_kind;
		logic [7:0]  device_id;
		logic [7:0]  func_code;
		logic [15:0] start_address;
		logic [10:0] quantity;
		logic [10:0] value_index;
		logic [15:0] value;
		logic [1:0]  status;
		logic        last;
	} result_t;

	// What the back end has to expand for one accepted byte.
	typedef enum logic [1:0] {
		JOB_NONE,
		JOB_COILS,
		JOB_VALUE
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic        summary;
		logic [1:0]  status;
		logic [7:0]  device_id;
		logic [7:0]  func_code;
		logic [15:0] start_address;
		logic [10:0] quantity;
		logic [10:0] value_index;
		logic [15:0] value;
	} job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_VALUES,
		BK_SUMMARY
	} bk_state_t;

	function automatic logic is_read_bits(input logic [7:0] f);
		return (f == FC_READ_COILS) || (f == FC_READ_DISCRETE);
	endfunction

	function automatic logic is_read_regs(input logic [7:0] f);
		return (f == FC_READ_HOLDING) || (f == FC_READ_INPUT);
	endfunction

	function automatic logic is_write(input logic [7:0] f);
		return (f == FC_WRITE_COIL) || (f == FC_WRITE_REG) ||
			(f == FC_WRITE_COILS) || (f == FC_WRITE_REGS);
	endfunction

	// One byte through the reflected CRC-16, one bit per step.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### rtl/mrp_front.sv
// ----------------------------------------------------------------------------
// Modbus RTU parser front end
// Tracks the frame position, decodes header fields, runs the CRC and turns
// each accepted byte into at most one job for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mrp_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           check_crc,
	input  wire logic           accept,
	input  wire mrp_pkg::frame_t frame,
	output logic                job_valid,
	output mrp_pkg::job_t       job
);
	import mrp_pkg::*;

	logic [POS_W-1:0] pos_q, pos_n;
	logic [7:0]       slave_q, slave_n;
	logic [7:0]       func_q, func_n;
	logic [7:0]       bcount_q, bcount_n;
	logic [15:0]      hold_q, hold_n;
	logic [15:0]      addr_q, addr_n;
	logic [10:0]      qty_q, qty_n;
	logic [15:0]      crc_q, crc_n;
	logic [15:0]      crcrx_q, crcrx_n;
	logic             bad_q, bad_n;

	logic [7:0]       b;
	logic             e;
	logic [LEN_W-1:0] pl, off, crc_pos, data_end, count, need;
	logic             in_range, rd, wr, known;

	// Per-byte decode: next frame state and the job this byte causes.
	always_comb begin
		b         = frame.frame_byte;
		e         = frame.frame_end;
		pl        = LEN_W'(pos_q);
		off       = pl - LEN_W'(3);
		in_range  = pos_q < POS_W'(MAX_FRAME_BYTES);
		rd        = is_read_bits(func_q) || is_read_regs(func_q);
		wr        = is_write(func_q);
		known     = (pl < LEN_W'(2)) || rd || wr;
		data_end  = LEN_W'(bcount_q) + LEN_W'(3);
		crc_pos   = rd ? data_end : (wr ? LEN_W'(6) : '0);

		pos_n    = pos_q;
		slave_n  = slave_q;
		func_n   = func_q;
		bcount_n = bcount_q;
		hold_n   = hold_q;
		addr_n   = addr_q;
		qty_n    = qty_q;
		crc_n    = crc_q;
		crcrx_n  = crcrx_q;
		bad_n    = bad_q;

		job      = '0;
		job.kind = JOB_NONE;

		if (in_range) begin
			// CRC accumulation over the body, capture of the received CRC.
			if (pl <= LEN_W'(2)) begin
				crc_n = crc16_byte(crc_q, b);
			end else if (known) begin
				if (pl < crc_pos) begin
					crc_n = crc16_byte(crc_q, b);
				end else if (pl == crc_pos) begin
					crcrx_n = {8'h00, b};
				end else if (pl == crc_pos + LEN_W'(1)) begin
					crcrx_n = crcrx_q | {b, 8'h00};
				end
			end

			// Field decoding by position and function code.
			if (pl == LEN_W'(0)) begin
				slave_n = b;
			end else if (pl == LEN_W'(1)) begin
				func_n = b;
				if ((b == FC_WRITE_COIL) || (b == FC_WRITE_REG)) begin
					qty_n = 11'd1;
				end else if (!(is_read_bits(b) || is_read_regs(b) || is_write(b))) begin
					bad_n = 1'b1;
				end
			end else if (is_read_bits(func_q)) begin
				if (pl == LEN_W'(2)) begin
					bcount_n = b;
					qty_n    = {b, 3'b000};
				end else if ((pl < data_end) && !e) begin
					job.kind        = JOB_COILS;
					job.value_index = {off[7:0], 3'b000};
					job.value       = {8'h00, b};
				end
			end else if (is_read_regs(func_q)) begin
				if (pl == LEN_W'(2)) begin
					bcount_n = b;
					qty_n    = 11'(b >> 1);
				end else if (pl < data_end) begin
					if (!off[0]) begin
						hold_n = {b, 8'h00};
					end else if (!e) begin
						job.kind        = JOB_VALUE;
						job.value_index = 11'(off >> 1);
						job.value       = hold_q | {8'h00, b};
					end
				end
			end else if (is_write(func_q)) begin
				if (pl == LEN_W'(2)) begin
					addr_n = {b, 8'h00};
				end else if (pl == LEN_W'(3)) begin
					addr_n = addr_q | {8'h00, b};
				end else if (pl == LEN_W'(4)) begin
					hold_n = {b, 8'h00};
				end else if (pl == LEN_W'(5)) begin
					hold_n = hold_q | {8'h00, b};
					if ((func_q == FC_WRITE_COILS) || (func_q == FC_WRITE_REGS)) begin
						qty_n = (hold_n > 16'(QTY_MAX)) ? QTY_MAX : hold_n[10:0];
					end else if (!e) begin
						job.kind        = JOB_VALUE;
						job.value_index = '0;
						if (func_q == FC_WRITE_COIL) begin
							job.value = (hold_q[15:8] == COIL_ON) ? 16'd1 : 16'd0;
						end else begin
							job.value = hold_n;
						end
					end
				end
			end

			pos_n = pos_q + POS_W'(1);
		end

		// End-of-frame status from the updated state.
		count = LEN_W'(pos_n);
		need  = '0;
		if (count >= LEN_W'(3)) begin
			if (is_read_bits(func_n) || is_read_regs(func_n)) begin
				need = LEN_W'(bcount_n) + LEN_W'(5);
			end else if (is_write(func_n)) begin
				need = LEN_W'(8);
			end
		end
		job.summary = e;
		if (bad_n || (need == '0) || (count < need)) begin
			job.status = ST_MALFORMED;
		end else if (check_crc && (crcrx_n != crc_n)) begin
			job.status = ST_BAD_CRC;
		end else begin
			job.status = ST_OK;
		end

		// Header fields are a snapshot after this byte.
		job.device_id     = slave_n;
		job.func_code     = func_n;
		job.start_address = addr_n;
		job.quantity      = qty_n;

		job_valid = (job.kind != JOB_NONE) || e;

		// A finished frame starts over.
		if (e) begin
			pos_n    = '0;
			slave_n  = '0;
			func_n   = '0;
			bcount_n = '0;
			hold_n   = '0;
			addr_n   = '0;
			qty_n    = '0;
			crc_n    = CRC_INIT;
			crcrx_n  = '0;
			bad_n    = 1'b0;
		end
	end

	// Frame state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			slave_q  <= '0;
			func_q   <= '0;
			bcount_q <= '0;
			hold_q   <= '0;
			addr_q   <= '0;
			qty_q    <= '0;
			crc_q    <= CRC_INIT;
			crcrx_q  <= '0;
			bad_q    <= 1'b0;
		end else if (accept) begin
			pos_q    <= pos_n;
			slave_q  <= slave_n;
			func_q   <= func_n;
			bcount_q <= bcount_n;
			hold_q   <= hold_n;
			addr_q   <= addr_n;
			qty_q    <= qty_n;
			crc_q    <= crc_n;
			crcrx_q  <= crcrx_n;
			bad_q    <= bad_n;
		end
	end

endmodule

`default_nettype wire

### rtl/mrp_job_queue.sv
// ----------------------------------------------------------------------------
// Modbus RTU parser job queue
// Small FIFO that decouples the byte front end from the result back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mrp_job_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire mrp_pkg::job_t push_data,
	output logic               full,
	input  wire logic          pop,
	output mrp_pkg::job_t      pop_data,
	output logic               empty
);
	import mrp_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QPTR_W + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QPTR_W + 1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

### rtl/mrp_back.sv
// ----------------------------------------------------------------------------
// Modbus RTU parser back end
// Expands queued jobs into result items (eight coil bits or one register
// value; a frame summary after them or alone) held in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrp_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mrp_pkg::job_t q_data,
	input  wire logic          q_empty,
	output logic               q_pop,
	output mrp_pkg::result_t   result,
	output logic               empty,
	input  wire logic          pop
);
	import mrp_pkg::*;

	bk_state_t  st_q, st_n;
	job_t       job_q;
	logic [2:0] cnt_q;
	logic       out_valid_q;
	result_t    out_q;

	result_t    cur;
	logic       have;
	logic       val_done;
	logic       final_item;
	logic       load;
	logic       fire;
	logic       fetch;

	assign load   = !out_valid_q || pop;
	assign fire   = have && load;
	assign fetch  = !q_empty && ((st_q == BK_IDLE) || (fire && final_item));
	assign q_pop  = fetch;
	assign result = out_q;
	assign empty  = !out_valid_q;

	// Current result item for the state and counter.
	always_comb begin
		cur               = '0;
		cur.device_id     = job_q.device_id;
		cur.func_code     = job_q.func_code;
		cur.start_address = job_q.start_address;
		cur.quantity      = job_q.quantity;
		have              = 1'b0;
		val_done          = (job_q.kind == JOB_VALUE) || (cnt_q == 3'd7);
		final_item        = 1'b0;
		unique case (st_q)
			BK_IDLE: begin
				have = 1'b0;
			end
			BK_VALUES: begin
				have            = 1'b1;
				cur.item_kind   = KIND_VALUE;
				cur.status      = ST_OK;
				cur.value_index = job_q.value_index + 11'(cnt_q);
				if (job_q.kind == JOB_COILS) begin
					cur.value = {15'd0, job_q.value[cnt_q]};
				end else begin
					cur.value = job_q.value;
				end
				final_item = val_done && !job_q.summary;
				cur.last   = final_item;
			end
			BK_SUMMARY: begin
				have          = 1'b1;
				cur.item_kind = KIND_SUMMARY;
				cur.status    = job_q.status;
				final_item    = 1'b1;
				cur.last      = 1'b1;
			end
			default: begin
				have = 1'b0;
			end
		endcase
	end

	// Next state.
	always_comb begin
		st_n = st_q;
		priority if (fetch) begin
			st_n = (q_data.kind != JOB_NONE) ? BK_VALUES : BK_SUMMARY;
		end else if (fire && final_item) begin
			st_n = BK_IDLE;
		end else if (fire && (st_q == BK_VALUES) && val_done) begin
			st_n = BK_SUMMARY;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= BK_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_n;
			if (fetch) begin
				cnt_q <= '0;
			end else if (fire && (st_q == BK_VALUES)) begin
				cnt_q <= cnt_q + 3'd1;
			end
			if (load) begin
				out_valid_q <= fire;
			end
		end
	end

	// Job and output payload.
	always_ff @(posedge clk) begin
		if (fetch) begin
			job_q <= q_data;
		end
		if (fire) begin
			out_q <= cur;
		end
	end

endmodule

`default_nettype wire

### rtl/modbus_rtu_response_parser_core.sv
// ----------------------------------------------------------------------------
// Modbus RTU response parser core
// Parses response frames byte by byte, checks the CRC-16 and emits decoded
// coil bits, register values and an end-of-frame status.
// ----------------------------------------------------------------------------
// Usage:
// Bytes enter through push/full with frame.frame_end on the last byte of a
// frame. Results leave through empty/pop; result.last marks the final item
// caused by one byte. The user writes check_crc through cfg_valid/cfg_ready
// (always ready) only while the block is idle, which it does not enforce.
// A byte is classified combinationally, then queued as a job (four deep);
// the back end emits one item per cycle while pop keeps the output register
// free, so a coil byte gives eight items, a register value or single write
// one, and a summary one more. When the back end is idle, the first item
// of a byte is visible after the queue, job register and output register.
// The input side keeps taking one byte per cycle until the job queue fills.
// When pop stays low the output register and queue hold, and full rises
// once the queue is full; nothing is lost.
// Reset clears the frame state, the queue and the output register and sets
// check_crc to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_response_parser_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire mrp_pkg::frame_t  frame,
	output logic                  empty,
	input  wire logic             pop,
	output mrp_pkg::result_t      result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic             cfg_data
);
	import mrp_pkg::*;

	logic check_crc_q;
	logic accept;
	logic job_valid;
	job_t job;
	logic q_full;
	logic q_empty;
	logic q_pop;
	job_t q_data;

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign accept    = push && !q_full;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_crc_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			check_crc_q <= cfg_data;
		end
	end

	mrp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.check_crc (check_crc_q),
		.accept    (accept),
		.frame     (frame),
		.job_valid (job_valid),
		.job       (job)
	);

	mrp_job_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && job_valid),
		.push_data (job),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_data),
		.empty     (q_empty)
	);

	mrp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (q_data),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

endmodule

`default_nettype wire

### rtl/mrp_checker.sv
// ----------------------------------------------------------------------------
// Modbus RTU parser port checker
// Watches the top-level ports of the parser core over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "modbus_rtu_response_parser_core_defines.svh"

module mrp_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             empty,
	input wire logic             pop,
	input wire mrp_pkg::result_t result
);
	import mrp_pkg::*;

	logic out_value;
	logic out_summary;
	logic out_coil;

	// Kind of the result item on the ports.
	assign out_value   = !empty && (result.item_kind == KIND_VALUE);
	assign out_summary = !empty && (result.item_kind == KIND_SUMMARY);
	assign out_coil    = out_value && is_read_bits(result.func_code);

	// A waiting result item holds until it is taken.
	`MRP_ASSERT_NXT(a_hold_stalled, clk, arst_n, !empty && !pop, !empty && $stable(result))

	// A frame summary always closes the items of its byte.
	`MRP_ASSERT_IMP(a_summary_last, clk, arst_n, out_summary, result.last)

	// Decoded values never carry a status.
	`MRP_ASSERT_IMP(a_value_status, clk, arst_n, out_value, result.status == ST_OK)

	// Coil and discrete input values are single bits.
	`MRP_ASSERT_IMP(a_coil_bit, clk, arst_n, out_coil, result.value[15:1] == 15'd0)

endmodule

bind modbus_rtu_response_parser_core mrp_checker u_mrp_checker (.*);

`default_nettype wire
